// File: rtl/core/obb_pkg.sv
package obb_pkg;

	localparam int COORD_WIDTH_DEF    = 16;
	localparam int AXIS_FRAC_BITS_DEF = 14;
	localparam int NUM_AXES           = 3;
	localparam int PIPE_DEPTH         = 8;

endpackage

// File: rtl/core/obb_pair_overlap_test.sv
// Result: an accepted start passes through every stage register to the done strobe carrying hit.
// Throughput: one box pair per cycle; busy stays low, the 8-stage datapath
// (products, dot sums, cross terms, radii, compares) is fully pipelined.
// Reset: arst_n low clears every stage valid bit at once; the datapath
// registers carry no reset. The receiver cannot stall: done lasts one cycle.
module obb_pair_overlap_test #(
	parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEF,
	parameter int AXIS_FRAC_BITS = obb_pkg::AXIS_FRAC_BITS_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  start,
	output logic                                                  busy,
	input  logic [obb_pkg::NUM_AXES*COORD_WIDTH-1:0]              a_center,
	input  logic [obb_pkg::NUM_AXES*(AXIS_FRAC_BITS+2)-1:0]       a_axis_0,
	input  logic [obb_pkg::NUM_AXES*(AXIS_FRAC_BITS+2)-1:0]       a_axis_1,
	input  logic [obb_pkg::NUM_AXES*(AXIS_FRAC_BITS+2)-1:0]       a_axis_2,
	input  logic [obb_pkg::NUM_AXES*COORD_WIDTH-1:0]              a_half_len,
	input  logic [obb_pkg::NUM_AXES*COORD_WIDTH-1:0]              b_center,
	input  logic [obb_pkg::NUM_AXES*(AXIS_FRAC_BITS+2)-1:0]       b_axis_0,
	input  logic [obb_pkg::NUM_AXES*(AXIS_FRAC_BITS+2)-1:0]       b_axis_1,
	input  logic [obb_pkg::NUM_AXES*(AXIS_FRAC_BITS+2)-1:0]       b_axis_2,
	input  logic [obb_pkg::NUM_AXES*COORD_WIDTH-1:0]              b_half_len,
	output logic                                                  done,
	output logic                                                  hit
);

	localparam int CW   = COORD_WIDTH;
	localparam int F    = AXIS_FRAC_BITS;
	localparam int AW   = AXIS_FRAC_BITS + 2;
	localparam int DW   = CW + 1;
	localparam int RW   = 2 * AW + 2;
	localparam int FDW  = DW + AW + 2;
	localparam int CRW  = 2 * AW + 1;
	localparam int CDW  = DW + CRW + 2;
	localparam int CAW  = CRW + AW + 2;
	localparam int FRW  = RW + CW + 3;
	localparam int FCW  = (FRW > FDW + F) ? FRW : FDW + F;
	localparam int XRW  = CAW + CW + 2;
	localparam int XCW  = (XRW > CDW + F) ? XRW : CDW + F;

	logic [obb_pkg::NUM_AXES*AW-1:0] a_ax_in [3];
	logic [obb_pkg::NUM_AXES*AW-1:0] b_ax_in [3];
	logic signed [AW-1:0] a_in [3][3];
	logic signed [AW-1:0] b_in [3][3];
	logic signed [DW-1:0] d_in [3];
	logic [CW-1:0] ha_in [3];
	logic [CW-1:0] hb_in [3];

	logic [obb_pkg::PIPE_DEPTH-1:0] vld_q;

	// stage 1: unpacked operands
	logic signed [DW-1:0] d_s1 [3];
	logic signed [AW-1:0] a_s1 [3][3];
	logic signed [AW-1:0] b_s1 [3][3];
	logic [CW-1:0] ha_s1 [3];
	logic [CW-1:0] hb_s1 [3];

	// stage 2: first products
	logic signed [2*AW-1:0] rp_s2 [3][3][3];
	logic signed [DW+AW-1:0] fap_s2 [3][3];
	logic signed [DW+AW-1:0] fbp_s2 [3][3];
	logic signed [2*AW-1:0] xp1_s2 [3][3][3];
	logic signed [2*AW-1:0] xp2_s2 [3][3][3];
	logic signed [DW-1:0] d_s2 [3];
	logic signed [AW-1:0] a_s2 [3][3];
	logic signed [AW-1:0] b_s2 [3][3];
	logic [CW-1:0] ha_s2 [3];
	logic [CW-1:0] hb_s2 [3];

	// stage 3: dot sums and cross axes
	logic signed [RW-1:0] r_s3 [3][3];
	logic signed [FDW-1:0] fad_s3 [3];
	logic signed [FDW-1:0] fbd_s3 [3];
	logic signed [CRW-1:0] c_s3 [3][3][3];
	logic signed [DW-1:0] d_s3 [3];
	logic signed [AW-1:0] a_s3 [3][3];
	logic signed [AW-1:0] b_s3 [3][3];
	logic [CW-1:0] ha_s3 [3];
	logic [CW-1:0] hb_s3 [3];

	// stage 4
	logic [RW+CW-1:0] frap_s4 [3][3];
	logic [RW+CW-1:0] frbp_s4 [3][3];
	logic [FDW-1:0] fal_s4 [3];
	logic [FDW-1:0] fbl_s4 [3];
	logic [CW-1:0] hfa_s4 [3];
	logic [CW-1:0] hfb_s4 [3];
	logic signed [DW+CRW-1:0] cdp_s4 [3][3][3];
	logic signed [CRW+AW-1:0] cap_s4 [3][3][3][3];
	logic signed [CRW+AW-1:0] cbp_s4 [3][3][3][3];
	logic [CW-1:0] ha_s4 [3];
	logic [CW-1:0] hb_s4 [3];

	// stage 5
	logic [FCW-1:0] far_s5 [3];
	logic [FCW-1:0] fbr_s5 [3];
	logic [FCW-1:0] fal_s5 [3];
	logic [FCW-1:0] fbl_s5 [3];
	logic signed [CDW-1:0] cd_s5 [3][3];
	logic signed [CAW-1:0] ca_s5 [3][3][3];
	logic signed [CAW-1:0] cb_s5 [3][3][3];
	logic [CW-1:0] ha_s5 [3];
	logic [CW-1:0] hb_s5 [3];

	// stage 6
	logic [5:0] fsep_s6;
	logic [CDW-1:0] xl_s6 [3][3];
	logic [CAW+CW-1:0] xpa_s6 [3][3][3];
	logic [CAW+CW-1:0] xpb_s6 [3][3][3];

	// stage 7
	logic [5:0] fsep_s7;
	logic [XCW-1:0] xl_s7 [3][3];
	logic [XCW-1:0] xr_s7 [3][3];

	// stage 8
	logic hit_s8;

	assign busy = 1'b0;
	assign done = vld_q[obb_pkg::PIPE_DEPTH-1];
	assign hit  = hit_s8;

	always_comb begin
		a_ax_in[0] = a_axis_0;
		a_ax_in[1] = a_axis_1;
		a_ax_in[2] = a_axis_2;
		b_ax_in[0] = b_axis_0;
		b_ax_in[1] = b_axis_1;
		b_ax_in[2] = b_axis_2;
		for (int m = 0; m < 3; m++) begin
			d_in[m]  = $signed({a_center[m*CW+CW-1], a_center[m*CW +: CW]})
				- $signed({b_center[m*CW+CW-1], b_center[m*CW +: CW]});
			ha_in[m] = a_half_len[m*CW +: CW];
			hb_in[m] = b_half_len[m*CW +: CW];
		end
		for (int i = 0; i < 3; i++) begin
			for (int m = 0; m < 3; m++) begin
				a_in[i][m] = $signed(a_ax_in[i][m*AW +: AW]);
				b_in[i][m] = $signed(b_ax_in[i][m*AW +: AW]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[obb_pkg::PIPE_DEPTH-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		// stage 1
		d_s1  <= d_in;
		a_s1  <= a_in;
		b_s1  <= b_in;
		ha_s1 <= ha_in;
		hb_s1 <= hb_in;

		// stage 2
		for (int i = 0; i < 3; i++) begin
			for (int m = 0; m < 3; m++) begin
				fap_s2[i][m] <= d_s1[m] * a_s1[i][m];
				fbp_s2[i][m] <= d_s1[m] * b_s1[i][m];
			end
			for (int k = 0; k < 3; k++) begin
				for (int m = 0; m < 3; m++) begin
					rp_s2[i][k][m] <= a_s1[i][m] * b_s1[k][m];
				end
				xp1_s2[i][k][0] <= a_s1[i][1] * b_s1[k][2];
				xp2_s2[i][k][0] <= a_s1[i][2] * b_s1[k][1];
				xp1_s2[i][k][1] <= a_s1[i][2] * b_s1[k][0];
				xp2_s2[i][k][1] <= a_s1[i][0] * b_s1[k][2];
				xp1_s2[i][k][2] <= a_s1[i][0] * b_s1[k][1];
				xp2_s2[i][k][2] <= a_s1[i][1] * b_s1[k][0];
			end
		end
		d_s2  <= d_s1;
		a_s2  <= a_s1;
		b_s2  <= b_s1;
		ha_s2 <= ha_s1;
		hb_s2 <= hb_s1;

		// stage 3
		for (int i = 0; i < 3; i++) begin
			fad_s3[i] <= FDW'(fap_s2[i][0]) + FDW'(fap_s2[i][1]) + FDW'(fap_s2[i][2]);
			fbd_s3[i] <= FDW'(fbp_s2[i][0]) + FDW'(fbp_s2[i][1]) + FDW'(fbp_s2[i][2]);
			for (int k = 0; k < 3; k++) begin
				r_s3[i][k] <= RW'(rp_s2[i][k][0]) + RW'(rp_s2[i][k][1])
					+ RW'(rp_s2[i][k][2]);
				for (int m = 0; m < 3; m++) begin
					c_s3[i][k][m] <= CRW'(xp1_s2[i][k][m]) - CRW'(xp2_s2[i][k][m]);
				end
			end
		end
		d_s3  <= d_s2;
		a_s3  <= a_s2;
		b_s3  <= b_s2;
		ha_s3 <= ha_s2;
		hb_s3 <= hb_s2;

		// stage 4
		for (int i = 0; i < 3; i++) begin
			fal_s4[i] <= fad_s3[i][FDW-1] ? FDW'(-fad_s3[i]) : FDW'(fad_s3[i]);
			fbl_s4[i] <= fbd_s3[i][FDW-1] ? FDW'(-fbd_s3[i]) : FDW'(fbd_s3[i]);
			for (int k = 0; k < 3; k++) begin
				// face A axis i against B axis k; face B axis i against A axis k
				frap_s4[i][k] <= (r_s3[i][k][RW-1] ? RW'(-r_s3[i][k]) : RW'(r_s3[i][k]))
					* hb_s3[k];
				frbp_s4[i][k] <= (r_s3[k][i][RW-1] ? RW'(-r_s3[k][i]) : RW'(r_s3[k][i]))
					* ha_s3[k];
			end
			for (int j = 0; j < 3; j++) begin
				for (int m = 0; m < 3; m++) begin
					cdp_s4[i][j][m] <= d_s3[m] * c_s3[i][j][m];
				end
				for (int k = 0; k < 3; k++) begin
					for (int m = 0; m < 3; m++) begin
						cap_s4[i][j][k][m] <= c_s3[i][j][m] * a_s3[k][m];
						cbp_s4[i][j][k][m] <= c_s3[i][j][m] * b_s3[k][m];
					end
				end
			end
		end
		hfa_s4 <= ha_s3;
		hfb_s4 <= hb_s3;
		ha_s4  <= ha_s3;
		hb_s4  <= hb_s3;

		// stage 5
		for (int i = 0; i < 3; i++) begin
			far_s5[i] <= FCW'(frap_s4[i][0]) + FCW'(frap_s4[i][1]) + FCW'(frap_s4[i][2])
				+ FCW'({hfa_s4[i], {(2*F){1'b0}}});
			fbr_s5[i] <= FCW'(frbp_s4[i][0]) + FCW'(frbp_s4[i][1]) + FCW'(frbp_s4[i][2])
				+ FCW'({hfb_s4[i], {(2*F){1'b0}}});
			fal_s5[i] <= FCW'({fal_s4[i], {F{1'b0}}});
			fbl_s5[i] <= FCW'({fbl_s4[i], {F{1'b0}}});
			for (int j = 0; j < 3; j++) begin
				cd_s5[i][j] <= CDW'(cdp_s4[i][j][0]) + CDW'(cdp_s4[i][j][1])
					+ CDW'(cdp_s4[i][j][2]);
				for (int k = 0; k < 3; k++) begin
					ca_s5[i][j][k] <= CAW'(cap_s4[i][j][k][0]) + CAW'(cap_s4[i][j][k][1])
						+ CAW'(cap_s4[i][j][k][2]);
					cb_s5[i][j][k] <= CAW'(cbp_s4[i][j][k][0]) + CAW'(cbp_s4[i][j][k][1])
						+ CAW'(cbp_s4[i][j][k][2]);
				end
			end
		end
		ha_s5 <= ha_s4;
		hb_s5 <= hb_s4;

		// stage 6
		for (int i = 0; i < 3; i++) begin
			fsep_s6[i]   <= fal_s5[i] > far_s5[i];
			fsep_s6[i+3] <= fbl_s5[i] > fbr_s5[i];
			for (int j = 0; j < 3; j++) begin
				xl_s6[i][j] <= cd_s5[i][j][CDW-1] ? CDW'(-cd_s5[i][j]) : CDW'(cd_s5[i][j]);
				for (int k = 0; k < 3; k++) begin
					xpa_s6[i][j][k] <= (ca_s5[i][j][k][CAW-1] ? CAW'(-ca_s5[i][j][k])
						: CAW'(ca_s5[i][j][k])) * ha_s5[k];
					xpb_s6[i][j][k] <= (cb_s5[i][j][k][CAW-1] ? CAW'(-cb_s5[i][j][k])
						: CAW'(cb_s5[i][j][k])) * hb_s5[k];
				end
			end
		end

		// stage 7: radii drop the axes that form the cross product
		fsep_s7 <= fsep_s6;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				xl_s7[i][j] <= XCW'({xl_s6[i][j], {F{1'b0}}});
				xr_s7[i][j] <= XCW'(i == 0 ? '0 : xpa_s6[i][j][0])
					+ XCW'(i == 1 ? '0 : xpa_s6[i][j][1])
					+ XCW'(i == 2 ? '0 : xpa_s6[i][j][2])
					+ XCW'(j == 0 ? '0 : xpb_s6[i][j][0])
					+ XCW'(j == 1 ? '0 : xpb_s6[i][j][1])
					+ XCW'(j == 2 ? '0 : xpb_s6[i][j][2]);
			end
		end
	end

	always_ff @(posedge clk) begin : cross_compare
		logic sep;
		sep = |fsep_s7;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				sep = sep | (xl_s7[i][j] > xr_s7[i][j]);
			end
		end
		hit_s8 <= ~sep;
	end

endmodule

// File: test/obb_pair_overlap_test_tb.sv
`timescale 1ns / 100ps

module obb_pair_overlap_test_tb;

	localparam int CW   = obb_pkg::COORD_WIDTH_DEF;
	localparam int AF   = obb_pkg::AXIS_FRAC_BITS_DEF;
	localparam int AW   = AF + 2;
	localparam int NA   = obb_pkg::NUM_AXES;
	localparam int VW   = NA * CW;
	localparam int XW   = NA * AW;
	localparam int STALL_LIMIT = 2000;

	typedef logic signed [127:0] acc_t;

	typedef struct {
		logic [VW-1:0] ac, ah, bc, bh;
		logic [XW-1:0] aa [3];
		logic [XW-1:0] ba [3];
	} box_pair_t;

	class hit_scoreboard;
		bit pending_hits [$];
		int errors;

		function automatic acc_t sx(logic [XW-1:0] v, int k);
			logic signed [AW-1:0] f;
			f = v[k*AW +: AW];
			return acc_t'(f);
		endfunction

		function automatic acc_t sc(logic [VW-1:0] v, int k);
			logic signed [CW-1:0] f;
			f = v[k*CW +: CW];
			return acc_t'(f);
		endfunction

		function automatic acc_t dot3(acc_t u [3], acc_t v [3]);
			return u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
		endfunction

		function automatic acc_t mag(acc_t x);
			return (x < 0) ? -x : x;
		endfunction

		// radius of a box on axis n, skipping one of its axes (3 = none)
		function automatic acc_t radius(acc_t n [3], acc_t ax [3][3], acc_t h [3], int skip);
			acc_t r;
			r = 0;
			for (int k = 0; k < 3; k++)
				if (k != skip) r += mag(dot3(n, ax[k])) * h[k];
			return r;
		endfunction

		function automatic bit overlaps(box_pair_t p);
			acc_t a [3][3], b [3][3], d [3], ha [3], hb [3], c [3], l;
			bit ov;
			ov = 1;
			for (int i = 0; i < 3; i++) begin
				d[i]  = sc(p.ac, i) - sc(p.bc, i);
				ha[i] = acc_t'(p.ah[i*CW +: CW]);
				hb[i] = acc_t'(p.bh[i*CW +: CW]);
				for (int j = 0; j < 3; j++) begin
					a[i][j] = sx(p.aa[i], j);
					b[i][j] = sx(p.ba[i], j);
				end
			end
			for (int i = 0; i < 3; i++) begin
				l = mag(dot3(d, a[i])) <<< AF;
				if (l > (ha[i] <<< (2*AF)) + radius(a[i], b, hb, 3)) ov = 0;
				l = mag(dot3(d, b[i])) <<< AF;
				if (l > radius(b[i], a, ha, 3) + (hb[i] <<< (2*AF))) ov = 0;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					c[0] = a[i][1]*b[j][2] - a[i][2]*b[j][1];
					c[1] = a[i][2]*b[j][0] - a[i][0]*b[j][2];
					c[2] = a[i][0]*b[j][1] - a[i][1]*b[j][0];
					l = mag(dot3(d, c)) <<< AF;
					if (l > radius(c, a, ha, i) + radius(c, b, hb, j)) ov = 0;
				end
			return ov;
		endfunction

		function void note_pair(box_pair_t p);
			pending_hits.push_back(overlaps(p));
		endfunction

		function void check_hit(logic got);
			bit want;
			if (pending_hits.size() == 0) begin
				report("done with no pair outstanding");
				return;
			end
			want = pending_hits.pop_front();
			if (got !== want)
				report($sformatf("hit mismatch: got %0b want %0b", got, want));
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 50) $display("ERROR %0t: %s", $time, msg);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done, hit;
	logic [VW-1:0] a_center = '0, a_half_len = '0, b_center = '0, b_half_len = '0;
	logic [XW-1:0] a_axis_0 = '0, a_axis_1 = '0, a_axis_2 = '0;
	logic [XW-1:0] b_axis_0 = '0, b_axis_1 = '0, b_axis_2 = '0;

	hit_scoreboard sb = new();
	int idle_cycles = 0;
	bit calm;

	always #1 clk = ~clk;

	obb_pair_overlap_test i_dut (
		.clk, .arst_n, .start, .busy,
		.a_center, .a_axis_0, .a_axis_1, .a_axis_2, .a_half_len,
		.b_center, .b_axis_0, .b_axis_1, .b_axis_2, .b_half_len,
		.done, .hit
	);

	always @(posedge clk) begin
		if (arst_n && done) sb.check_hit(hit);
		if (arst_n && ((start && !busy) || done)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("obb_pair_overlap_test_tb: done, errors");
			$finish;
		end
	end

	function automatic logic [XW-1:0] pack_axis(int x, int y, int z);
		logic [AW-1:0] fx, fy, fz;
		fx = AW'(x); fy = AW'(y); fz = AW'(z);
		return {fz, fy, fx};
	endfunction

	function automatic logic [VW-1:0] pack_vec(int x, int y, int z);
		logic [CW-1:0] fx, fy, fz;
		fx = CW'(x); fy = CW'(y); fz = CW'(z);
		return {fz, fy, fx};
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// drive one box pair, hold start until it is taken
	task automatic send_pair(box_pair_t p);
		while (!calm && $urandom_range(99) < 34) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		a_center <= p.ac; a_half_len <= p.ah; b_center <= p.bc; b_half_len <= p.bh;
		a_axis_0 <= p.aa[0]; a_axis_1 <= p.aa[1]; a_axis_2 <= p.aa[2];
		b_axis_0 <= p.ba[0]; b_axis_1 <= p.ba[1]; b_axis_2 <= p.ba[2];
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_pair(p);
	endtask

	function automatic box_pair_t identity_pair(logic [VW-1:0] ac, logic [VW-1:0] bc,
			logic [VW-1:0] ah, logic [VW-1:0] bh);
		box_pair_t p;
		p.ac = ac; p.bc = bc; p.ah = ah; p.bh = bh;
		p.aa[0] = pack_axis(1 << AF, 0, 0);
		p.aa[1] = pack_axis(0, 1 << AF, 0);
		p.aa[2] = pack_axis(0, 0, 1 << AF);
		p.ba = p.aa;
		return p;
	endfunction

	// random rotation-ish axes: mostly small or unit-scale, sometimes raw bits
	function automatic logic [XW-1:0] rand_axis();
		int r;
		r = $urandom_range(3);
		if (r == 0) return rand48();
		if (r == 1) return pack_axis($urandom_range(0, 2*(1<<AF)) - (1<<AF),
				$urandom_range(0, 2*(1<<AF)) - (1<<AF), $urandom_range(0, 2*(1<<AF)) - (1<<AF));
		if (r == 2) return pack_axis(($urandom_range(1) ? 1 : -1) << AF, 0, 0);
		return pack_axis(0, $urandom_range(0, 2*(1<<AF)) - (1<<AF), 1 << (AF-1));
	endfunction

	function automatic logic [VW-1:0] rand_coord(int span);
		if ($urandom_range(7) == 0) return rand48();
		return pack_vec($urandom_range(0, 2*span) - span,
				$urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span);
	endfunction

	initial begin
		box_pair_t p;
		int span;
		calm = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// touching faces (equal, not separated), just apart, coincident, extremes
		send_pair(identity_pair(pack_vec(0, 0, 0), pack_vec(512, 0, 0),
				pack_vec(256, 256, 256), pack_vec(256, 256, 256)));
		send_pair(identity_pair(pack_vec(0, 0, 0), pack_vec(513, 0, 0),
				pack_vec(256, 256, 256), pack_vec(256, 256, 256)));
		send_pair(identity_pair('0, '0, '0, '0));
		send_pair(identity_pair('1, '0, '1, '1));
		send_pair(identity_pair({NA{1'b0, {CW-1{1'b1}}}}, {NA{1'b1, {CW-1{1'b0}}}},
				'1, '1));
		send_pair(identity_pair({NA{1'b0, {CW-1{1'b1}}}}, {NA{1'b1, {CW-1{1'b0}}}},
				'0, '0));
		p = identity_pair(pack_vec(0, 0, 0), pack_vec(300, 300, 0),
				pack_vec(256, 256, 256), pack_vec(256, 256, 256));
		// rotate B by 45 degrees about z: only a cross axis may separate
		p.ba[0] = pack_axis(11585, 11585, 0);
		p.ba[1] = pack_axis(-11585, 11585, 0);
		send_pair(p);
		p.aa[0] = '1; p.aa[1] = {XW{1'b1}} >> 1; p.aa[2] = {1'b1, {XW-1{1'b0}}};
		send_pair(p);
		p.ba[0] = pack_axis(-(1 << (AF+1)), -(1 << (AF+1)), -(1 << (AF+1)));
		p.ba[2] = '1;
		send_pair(p);
		// parallel axes give zero cross products
		send_pair(identity_pair(pack_vec(100, -100, 50), pack_vec(-100, 100, -50),
				pack_vec(120, 30, 60), pack_vec(10, 200, 5)));
		for (int k = 0; k < 6; k++)
			send_pair(identity_pair(rand48(), rand48(), rand48(), rand48()));

		for (int n = 0; n < 1200; n++) begin
			calm = (n >= 500 && n < 650);
			span = $urandom_range(1) ? 1024 : 8192;
			p.ac = rand_coord(span); p.bc = rand_coord(span);
			p.ah = $urandom_range(9) == 0 ? rand48() :
					pack_vec($urandom_range(1024), $urandom_range(1024), $urandom_range(1024));
			p.bh = $urandom_range(9) == 0 ? rand48() :
					pack_vec($urandom_range(1024), $urandom_range(1024), $urandom_range(1024));
			for (int k = 0; k < 3; k++) begin
				p.aa[k] = rand_axis();
				p.ba[k] = rand_axis();
			end
			send_pair(p);
		end
		start <= 0;

		while (sb.pending_hits.size() != 0) @(posedge clk);
		repeat (2 * obb_pkg::PIPE_DEPTH) @(posedge clk);
		if (sb.errors == 0)
			$display("obb_pair_overlap_test_tb: done, clean");
		else
			$display("obb_pair_overlap_test_tb: done, errors");
		$finish;
	end

endmodule

// File: files.f
rtl/core/obb_pkg.sv
rtl/core/obb_pair_overlap_test.sv
test/obb_pair_overlap_test_tb.sv
